// ----- rtl/spm_pkg.sv -----
// ----------------------------------------------------------------------------
// Sparse polynomial multiplier package
// Request and result types, term store types and control structs.
// ----------------------------------------------------------------------------
package spm_pkg;

  localparam logic [1:0] OP_LOAD_A = 2'd0;
  localparam logic [1:0] OP_LOAD_B = 2'd1;
  localparam logic [1:0] OP_MUL    = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] coef;
    logic [7:0]         expo;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] prod_coef;
    logic [8:0]         prod_expo;
    logic               zero_poly;
    logic               overflow;
    logic               last;
  } out_res_t;

  typedef struct packed {
    logic signed [15:0] coef;
    logic [7:0]         expo;
  } term_t;

  typedef struct packed {
    logic we;
    logic inc;
    logic clear;
  } store_ctl_t;

  typedef struct packed {
    logic init;
    logic restart;
    logic step;
    logic commit;
  } scan_ctl_t;

endpackage

// ----- rtl/spm_term_store.sv -----
// ----------------------------------------------------------------------------
// Sparse polynomial term store
// Register file of terms with one write port, one read port and a fill count.
// ----------------------------------------------------------------------------
module spm_term_store import spm_pkg::*; #(
  parameter int unsigned MAX_TERMS = 8,
  localparam int unsigned IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1,
  localparam int unsigned CW = $clog2(MAX_TERMS + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  store_ctl_t      ctl,
  input  logic [IW-1:0]   wr_idx,
  input  term_t           wr_term,
  input  logic [IW-1:0]   rd_idx,
  output term_t           rd_term,
  output logic [CW-1:0]   count
);

  term_t         mem_r [MAX_TERMS];
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem_r[wr_idx] <= wr_term;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.clear) begin
      count_nxt = '0;
    end else if (ctl.inc) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign rd_term = mem_r[rd_idx];
  assign count   = count_r;

endmodule

// ----- rtl/spm_pair_scan.sv -----
// ----------------------------------------------------------------------------
// Sparse polynomial pair scan unit
// Shared exponent adder and key comparator that picks the next product term.
// ----------------------------------------------------------------------------
module spm_pair_scan import spm_pkg::*; #(
  parameter int unsigned MAX_TERMS = 8,
  localparam int unsigned IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1,
  localparam int unsigned KW = 9 + 2 * IW
) (
  input  logic          clk,
  input  logic          rst_n,
  input  scan_ctl_t     ctl,
  input  logic [7:0]    expo_a,
  input  logic [7:0]    expo_b,
  input  logic [IW-1:0] idx_a,
  input  logic [IW-1:0] idx_b,
  output logic [IW-1:0] best_a,
  output logic [IW-1:0] best_b,
  output logic [8:0]    best_expo
);

  // A key orders products by exponent, then by formation order.
  logic [KW-1:0] cand;
  logic [KW-1:0] best_r;
  logic [KW-1:0] prev_r;
  logic          first_r;
  logic          found_r;
  logic          take;

  assign cand = {9'(expo_a) + 9'(expo_b), idx_a, idx_b};
  assign take = ctl.step && (first_r || (cand < prev_r)) && (!found_r || (cand > best_r));

  always_ff @(posedge clk) begin
    if (take) begin
      best_r <= cand;
    end
    if (ctl.commit) begin
      prev_r <= best_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b1;
      found_r <= 1'b0;
    end else begin
      if (ctl.init) begin
        first_r <= 1'b1;
      end else if (ctl.commit) begin
        first_r <= 1'b0;
      end
      if (ctl.restart) begin
        found_r <= 1'b0;
      end else if (take) begin
        found_r <= 1'b1;
      end
    end
  end

  assign best_expo = best_r[KW-1 -: 9];
  assign best_a    = best_r[2*IW-1 -: IW];
  assign best_b    = best_r[IW-1:0];

endmodule

// ----- rtl/sparse_poly_multiply_sorted.sv -----
// ----------------------------------------------------------------------------
// Sparse polynomial multiplier with sorted term stores
// A load walks down from the fill count, one compare per cycle. A multiply
// scans all n1*n2 pairs once per result with the shared adder and
// comparator, then multiplies the chosen pair in S_MUL, and the result
// waits in S_EMIT for the handshake. An empty store gives one zero result.
// Synchronous active-low reset empties both stores and clears the drop flag.
// ----------------------------------------------------------------------------
module sparse_poly_multiply_sorted import spm_pkg::*; #(
  parameter int unsigned MAX_TERMS = 8
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output out_res_t out_data
);

  localparam int unsigned IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int unsigned CW = $clog2(MAX_TERMS + 1);
  localparam int unsigned RW = 2 * CW;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOAD = 5'b00010,
    S_SCAN = 5'b00100,
    S_MUL  = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t        state_r, state_nxt;
  logic          sel_r, sel_nxt;
  logic [IW-1:0] ptr_r, ptr_nxt;
  term_t         new_r, new_nxt;
  logic [IW-1:0] si_r, si_nxt;
  logic [IW-1:0] sj_r, sj_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic          dropped_r, dropped_nxt;
  out_res_t      out_r, out_nxt;

  store_ctl_t    ctl_a, ctl_b;
  scan_ctl_t     scan_ctl;
  logic [IW-1:0] rd_idx_a, rd_idx_b;
  term_t         rd_a, rd_b;
  logic [CW-1:0] count_a, count_b;
  logic [IW-1:0] best_a, best_b;
  logic [8:0]    best_expo;
  term_t         ld_term;
  logic          ld_we, ld_inc, clear_all;
  term_t         walk_term;
  logic [CW-1:0] count_sel;
  logic signed [31:0] prod;

  assign walk_term = sel_r ? rd_b : rd_a;
  assign count_sel = (in_data.op == OP_LOAD_B) ? count_b : count_a;
  assign prod      = $signed(rd_a.coef) * $signed(rd_b.coef);

  always_comb begin
    state_nxt   = state_r;
    sel_nxt     = sel_r;
    ptr_nxt     = ptr_r;
    new_nxt     = new_r;
    si_nxt      = si_r;
    sj_nxt      = sj_r;
    rem_nxt     = rem_r;
    dropped_nxt = dropped_r;
    out_nxt     = out_r;
    ld_we       = 1'b0;
    ld_inc      = 1'b0;
    ld_term     = new_r;
    clear_all   = 1'b0;
    scan_ctl    = '0;
    rd_idx_a    = ptr_r - IW'(1);
    rd_idx_b    = ptr_r - IW'(1);

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_data.op)
            OP_LOAD_A, OP_LOAD_B: begin
              if (count_sel == CW'(MAX_TERMS)) begin
                dropped_nxt = 1'b1;
              end else begin
                sel_nxt   = (in_data.op == OP_LOAD_B);
                ptr_nxt   = count_sel[IW-1:0];
                new_nxt   = '{coef: in_data.coef, expo: in_data.expo};
                state_nxt = S_LOAD;
              end
            end
            OP_MUL: begin
              if (count_a == '0 || count_b == '0) begin
                out_nxt   = '{prod_coef: '0, prod_expo: '0, zero_poly: 1'b1,
                              overflow: dropped_r, last: 1'b1};
                rem_nxt   = RW'(1);
                state_nxt = S_EMIT;
              end else begin
                rem_nxt          = RW'(count_a) * RW'(count_b);
                si_nxt           = '0;
                sj_nxt           = '0;
                scan_ctl.init    = 1'b1;
                scan_ctl.restart = 1'b1;
                state_nxt        = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_LOAD: begin
        ld_we = 1'b1;
        if (ptr_r == '0 || walk_term.expo > new_r.expo) begin
          ld_term   = new_r;
          ld_inc    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          ld_term = walk_term;
          ptr_nxt = ptr_r - IW'(1);
        end
      end
      S_SCAN: begin
        rd_idx_a      = si_r;
        rd_idx_b      = sj_r;
        scan_ctl.step = 1'b1;
        if ((CW'(sj_r) + CW'(1)) == count_b) begin
          sj_nxt = '0;
          if ((CW'(si_r) + CW'(1)) == count_a) begin
            state_nxt = S_MUL;
          end else begin
            si_nxt = si_r + IW'(1);
          end
        end else begin
          sj_nxt = sj_r + IW'(1);
        end
      end
      S_MUL: begin
        rd_idx_a  = best_a;
        rd_idx_b  = best_b;
        out_nxt   = '{prod_coef: prod, prod_expo: best_expo, zero_poly: 1'b0,
                      overflow: dropped_r, last: (rem_r == RW'(1))};
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_ready) begin
          if (rem_r == RW'(1)) begin
            clear_all   = 1'b1;
            dropped_nxt = 1'b0;
            state_nxt   = S_IDLE;
          end else begin
            rem_nxt          = rem_r - RW'(1);
            si_nxt           = '0;
            sj_nxt           = '0;
            scan_ctl.commit  = 1'b1;
            scan_ctl.restart = 1'b1;
            state_nxt        = S_SCAN;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign ctl_a = '{we: ld_we && !sel_r, inc: ld_inc && !sel_r, clear: clear_all};
  assign ctl_b = '{we: ld_we && sel_r, inc: ld_inc && sel_r, clear: clear_all};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      dropped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_r <= sel_nxt;
    ptr_r <= ptr_nxt;
    new_r <= new_nxt;
    si_r  <= si_nxt;
    sj_r  <= sj_nxt;
    rem_r <= rem_nxt;
    out_r <= out_nxt;
  end

  spm_term_store #(.MAX_TERMS(MAX_TERMS)) u_store_a (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl_a),
    .wr_idx  (ptr_r),
    .wr_term (ld_term),
    .rd_idx  (rd_idx_a),
    .rd_term (rd_a),
    .count   (count_a)
  );

  spm_term_store #(.MAX_TERMS(MAX_TERMS)) u_store_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl_b),
    .wr_idx  (ptr_r),
    .wr_term (ld_term),
    .rd_idx  (rd_idx_b),
    .rd_term (rd_b),
    .count   (count_b)
  );

  spm_pair_scan #(.MAX_TERMS(MAX_TERMS)) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (scan_ctl),
    .expo_a    (rd_a.expo),
    .expo_b    (rd_b.expo),
    .idx_a     (si_r),
    .idx_b     (sj_r),
    .best_a    (best_a),
    .best_b    (best_b),
    .best_expo (best_expo)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_EMIT);
  assign out_data  = out_r;

endmodule
